/* rtl/r2_outgoing_compelled_register_defines.svh */
// ---------------------------------------------------------------------------
// R2 outgoing register: assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef R2_OUTGOING_COMPELLED_REGISTER_DEFINES_SVH
`define R2_OUTGOING_COMPELLED_REGISTER_DEFINES_SVH

`ifndef SYNTH
// Property checked on every clock edge outside reset
`define R2OC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked on every clock edge, reset included
`define R2OC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define R2OC_ASSERT(lbl, prop, msg)
`define R2OC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/r2oc_pkg.sv */
// ---------------------------------------------------------------------------
// R2 outgoing register package
// Shared constants, codes, types and tone tables.
// ---------------------------------------------------------------------------
package r2oc_pkg;

    // Digit queue geometry
    localparam int QUEUE_DEPTH = 32;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int TONE_W  = 4;
    localparam int FREQ_W  = 11;
    localparam int EVENT_W = 3;
    localparam int PHASE_W = 2;
    localparam int COUNT_W = 6;
    localparam int CHAR_W  = 8;
    localparam int MS_W    = 16;
    localparam int GUARD_W = 10;

    // Stream and configuration port widths
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Request kinds
    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_FRAME  = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;
    localparam logic [1:0] REQ_HANGUP = 2'd3;

    // Detector frame kinds
    localparam logic [1:0] FRM_DIGIT   = 2'd0;
    localparam logic [1:0] FRM_BEGIN   = 2'd1;
    localparam logic [1:0] FRM_SILENT  = 2'd2;
    localparam logic [1:0] FRM_NOVOICE = 2'd3;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_QUEUED  = 3'd1;
    localparam logic [EVENT_W-1:0] EV_INVALID = 3'd2;
    localparam logic [EVENT_W-1:0] EV_FULL    = 3'd3;
    localparam logic [EVENT_W-1:0] EV_DONE    = 3'd4;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT = 3'd5;
    localparam logic [EVENT_W-1:0] EV_HANGUP  = 3'd6;

    // Reported phase codes
    localparam logic [PHASE_W-1:0] PC_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PC_ACK   = 2'd1;
    localparam logic [PHASE_W-1:0] PC_CEASE = 2'd2;
    localparam logic [PHASE_W-1:0] PC_GUARD = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RESP_TIMEOUT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_ACTIVITY  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GUARD        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_CHAR     = 3'd3;

    // Configuration reset values
    localparam logic [MS_W-1:0]    RESP_TIMEOUT_RST = 16'd5000;
    localparam logic [MS_W-1:0]    NO_ACTIVITY_RST  = 16'd1000;
    localparam logic [GUARD_W-1:0] GUARD_RST        = 10'd60;
    localparam logic [CHAR_W-1:0]  ACK_CHAR_RST     = 8'd49;

    // Sequencer phase
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_ACK   = 4'b0010,
        PH_CEASE = 4'b0100,
        PH_GUARD = 4'b1000
    } r2oc_phase_t;

    // One result item
    typedef struct packed {
        logic [COUNT_W-1:0] queued_count;
        logic [PHASE_W-1:0] phase_now;
        logic [EVENT_W-1:0] event_code;
        logic [FREQ_W-1:0]  tone_high_hz;
        logic [FREQ_W-1:0]  tone_low_hz;
        logic [TONE_W-1:0]  tone_number;
    } r2oc_result_t;

    // Forward character to tone number, 0 for a character that is not sent
    function automatic logic [TONE_W-1:0] char_to_tone(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        t = '0;
        if (c >= 8'h31 && c <= 8'h39)
        begin
            t = c - 8'h30;
        end
        else if (c == 8'h30)
        begin
            t = 8'd10;
        end
        else if (c >= 8'h42 && c <= 8'h46)
        begin
            t = c - 8'h37;
        end
        return t[TONE_W-1:0];
    endfunction

    // Lower frequency of the forward pair
    function automatic logic [FREQ_W-1:0] pair_low(input logic [TONE_W-1:0] t);
        logic [FREQ_W-1:0] f;
        case (t)
            4'd1, 4'd2, 4'd4, 4'd7, 4'd11: f = 11'd1380;
            4'd3, 4'd5, 4'd8, 4'd12:       f = 11'd1500;
            4'd6, 4'd9, 4'd13:             f = 11'd1620;
            4'd10, 4'd14:                  f = 11'd1740;
            4'd15:                         f = 11'd1860;
            default:                       f = 11'd0;
        endcase
        return f;
    endfunction

    // Higher frequency of the forward pair
    function automatic logic [FREQ_W-1:0] pair_high(input logic [TONE_W-1:0] t);
        logic [FREQ_W-1:0] f;
        case (t)
            4'd1:                              f = 11'd1500;
            4'd2, 4'd3:                        f = 11'd1620;
            4'd4, 4'd5, 4'd6:                  f = 11'd1740;
            4'd7, 4'd8, 4'd9, 4'd10:           f = 11'd1860;
            4'd11, 4'd12, 4'd13, 4'd14, 4'd15: f = 11'd1980;
            default:                           f = 11'd0;
        endcase
        return f;
    endfunction

endpackage

/* rtl/r2oc_skid.sv */
// ---------------------------------------------------------------------------
// R2 outgoing register: result skid buffer
// Two-entry output buffer so a result can be produced while one waits.
// ---------------------------------------------------------------------------
module r2oc_skid
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  r2oc_pkg::r2oc_result_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output r2oc_pkg::r2oc_result_t out_data
);
    import r2oc_pkg::*;

    logic         out_valid_reg;
    logic         skid_valid_reg;
    r2oc_result_t out_data_reg;
    r2oc_result_t skid_data_reg;
    logic         in_xfer;
    logic         out_xfer;

    assign in_ready  = !skid_valid_reg;
    assign in_xfer   = in_valid && !skid_valid_reg;
    assign out_xfer  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_xfer)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_xfer)
            begin
                if (out_valid_reg && !out_ready)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_xfer)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (in_xfer)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_data_reg <= in_data;
            end
            else
            begin
                out_data_reg <= in_data;
            end
        end
    end

endmodule

/* rtl/r2_outgoing_compelled_register.sv */
// ---------------------------------------------------------------------------
// R2 outgoing compelled register
// Forward-direction MFC register: digit queue and compelled handshake.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser selects push digit, detector frame,
//   millisecond tick or hangup, plus the frame kind; tdata holds the digit
//   to send and the backward character seen by the detector.
//   m_axis returns exactly one result per request: the forward tone and its
//   frequency pair, an event code, the phase and the number of queued digits.
//   cfg writes the four timing/acknowledge registers; it is always ready and
//   should only be used while no request is in flight.
// Throughput:
//   One request per cycle unless m_axis stalls. The state update is a single
//   pass of logic and the result is registered in the output buffer.
// Reset:
//   rst_n clears the sequencer to idle with an empty queue and restores the
//   register defaults. The queue store itself is not cleared.
// Stalls:
//   A two-entry output buffer lets one more request in while a result waits;
//   s_axis_tready drops only once both entries are held.
// ---------------------------------------------------------------------------
`include "r2_outgoing_compelled_register_defines.svh"

module r2_outgoing_compelled_register
(
    input  logic                               clk,
    input  logic                               rst_n,
    // tuser: req_type[1:0], frame_kind[3:2]
    // tdata: digit_char[7:0], detected_char[15:8]
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [r2oc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic [r2oc_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    // tdata: tone_number[3:0], tone_low_hz[14:4], tone_high_hz[25:15],
    //        event_code[28:26], phase_now[30:29], queued_count[36:31], zero
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [r2oc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [r2oc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [r2oc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import r2oc_pkg::*;

    // Configuration registers
    logic [MS_W-1:0]    resp_timeout_reg;
    logic [MS_W-1:0]    no_activity_reg;
    logic [GUARD_W-1:0] guard_ms_reg;
    logic [CHAR_W-1:0]  ack_char_reg;

    // Sequencer state
    r2oc_phase_t        phase_reg, phase_next;
    logic [QPTR_W-1:0]  head_reg, head_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [TONE_W-1:0]  tone_reg, tone_next;
    logic [MS_W-1:0]    wait_reg, wait_next;
    logic [MS_W-1:0]    idle_reg, idle_next;
    logic               silent_reg, silent_next;
    logic [GUARD_W-1:0] guard_reg, guard_next;
    logic [TONE_W-1:0]  queue_reg [QUEUE_DEPTH];

    // Request fields
    logic [1:0]         req_type;
    logic [1:0]         frame_kind;
    logic [CHAR_W-1:0]  digit_char;
    logic [CHAR_W-1:0]  detected_char;

    logic               in_xfer;
    logic               res_ready;
    logic [TONE_W-1:0]  push_tone;
    logic [MS_W-1:0]    wait_inc;
    logic [MS_W-1:0]    idle_inc;
    logic [QPTR_W:0]    wr_sum;
    logic [QPTR_W-1:0]  wr_idx;
    logic [QPTR_W-1:0]  head_inc;
    logic               q_we;
    logic               adv;
    logic [EVENT_W-1:0] ev;
    logic [TONE_W-1:0]  tone_out;
    logic [PHASE_W-1:0] phase_code;
    r2oc_result_t       result;
    r2oc_result_t       m_result;

    assign req_type      = s_axis_tuser[1:0];
    assign frame_kind    = s_axis_tuser[3:2];
    assign digit_char    = s_axis_tdata[7:0];
    assign detected_char = s_axis_tdata[15:8];

    assign in_xfer   = s_axis_tvalid && res_ready;
    assign s_axis_tready = res_ready;
    assign cfg_ready = 1'b1;

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_timeout_reg <= RESP_TIMEOUT_RST;
            no_activity_reg  <= NO_ACTIVITY_RST;
            guard_ms_reg     <= GUARD_RST;
            ack_char_reg     <= ACK_CHAR_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RESP_TIMEOUT: resp_timeout_reg <= cfg_data;
                CFG_NO_ACTIVITY:  no_activity_reg  <= cfg_data;
                CFG_GUARD:        guard_ms_reg     <= cfg_data[GUARD_W-1:0];
                CFG_ACK_CHAR:     ack_char_reg     <= cfg_data[CHAR_W-1:0];
                default:          ;
            endcase
        end
    end

    // Helpers: queue pointers and saturating counters
    assign push_tone = char_to_tone(digit_char);
    assign head_inc  = (head_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign wr_sum    = {1'b0, head_reg} + (QPTR_W + 1)'(fill_reg);
    assign wr_idx    = (wr_sum >= (QPTR_W + 1)'(QUEUE_DEPTH))
                       ? QPTR_W'(wr_sum - (QPTR_W + 1)'(QUEUE_DEPTH))
                       : wr_sum[QPTR_W-1:0];
    assign wait_inc  = (wait_reg == '1) ? wait_reg : wait_reg + 1'b1;
    assign idle_inc  = (idle_reg == '1) ? idle_reg : idle_reg + 1'b1;

    // Next state for one request
    always_comb
    begin
        phase_next  = phase_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        tone_next   = tone_reg;
        wait_next   = wait_reg;
        idle_next   = idle_reg;
        silent_next = silent_reg;
        guard_next  = guard_reg;
        q_we        = 1'b0;
        adv         = 1'b0;
        ev          = EV_NONE;

        case (req_type)
            REQ_PUSH:
            begin
                if (push_tone == '0)
                begin
                    ev = EV_INVALID;
                end
                else if (fill_reg >= FILL_W'(QUEUE_DEPTH))
                begin
                    ev = EV_FULL;
                end
                else
                begin
                    ev = EV_QUEUED;
                    if (phase_reg == PH_IDLE)
                    begin
                        // queue is empty when idle: start this digit straight away
                        tone_next   = push_tone;
                        head_next   = head_inc;
                        phase_next  = PH_ACK;
                        wait_next   = '0;
                        idle_next   = '0;
                        silent_next = 1'b0;
                    end
                    else
                    begin
                        q_we      = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            REQ_FRAME:
            begin
                idle_next = '0;
                if (phase_reg == PH_ACK && frame_kind == FRM_DIGIT)
                begin
                    wait_next = '0;
                    if (detected_char == ack_char_reg)
                    begin
                        tone_next   = '0;
                        phase_next  = PH_CEASE;
                        silent_next = 1'b0;
                    end
                end
                else if (phase_reg == PH_CEASE)
                begin
                    if (frame_kind == FRM_DIGIT)
                    begin
                        silent_next = 1'b0;
                    end
                    else if (frame_kind == FRM_SILENT)
                    begin
                        if (silent_reg)
                        begin
                            // backward tone has ceased
                            ev          = EV_DONE;
                            tone_next   = '0;
                            silent_next = 1'b0;
                            if (guard_ms_reg == '0)
                            begin
                                adv = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_GUARD;
                                guard_next = guard_ms_reg;
                            end
                        end
                        else
                        begin
                            silent_next = 1'b1;
                        end
                    end
                end
            end
            REQ_TICK:
            begin
                if (phase_reg == PH_ACK || phase_reg == PH_CEASE)
                begin
                    wait_next = wait_inc;
                    idle_next = idle_inc;
                    if (wait_inc >= resp_timeout_reg)
                    begin
                        ev = EV_TIMEOUT;
                    end
                    else if (idle_inc >= no_activity_reg)
                    begin
                        ev = EV_HANGUP;
                    end
                end
                else if (phase_reg == PH_GUARD)
                begin
                    if (guard_reg <= GUARD_W'(1))
                    begin
                        guard_next = '0;
                        adv        = 1'b1;
                    end
                    else
                    begin
                        guard_next = guard_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    ev = EV_HANGUP;
                end
            end
        endcase

        // Take the next queued digit, or drop to idle
        if (adv)
        begin
            if (fill_reg == '0)
            begin
                phase_next = PH_IDLE;
                tone_next  = '0;
            end
            else
            begin
                tone_next   = queue_reg[head_reg];
                head_next   = head_inc;
                fill_next   = fill_reg - 1'b1;
                phase_next  = PH_ACK;
                wait_next   = '0;
                idle_next   = '0;
                silent_next = 1'b0;
            end
        end

        // Failure or hangup: flush everything
        if (req_type == REQ_HANGUP || ev == EV_TIMEOUT || ev == EV_HANGUP)
        begin
            phase_next  = PH_IDLE;
            tone_next   = '0;
            head_next   = '0;
            fill_next   = '0;
            wait_next   = '0;
            idle_next   = '0;
            silent_next = 1'b0;
            guard_next  = '0;
        end
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            head_reg   <= '0;
            fill_reg   <= '0;
            tone_reg   <= '0;
            wait_reg   <= '0;
            idle_reg   <= '0;
            silent_reg <= 1'b0;
            guard_reg  <= '0;
        end
        else if (in_xfer)
        begin
            phase_reg  <= phase_next;
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            tone_reg   <= tone_next;
            wait_reg   <= wait_next;
            idle_reg   <= idle_next;
            silent_reg <= silent_next;
            guard_reg  <= guard_next;
        end
    end

    // Digit store
    always_ff @(posedge clk)
    begin
        if (in_xfer && q_we)
        begin
            queue_reg[wr_idx] <= push_tone;
        end
    end

    // Result for this request
    always_comb
    begin
        unique case (phase_next)
            PH_IDLE:  phase_code = PC_IDLE;
            PH_ACK:   phase_code = PC_ACK;
            PH_CEASE: phase_code = PC_CEASE;
            PH_GUARD: phase_code = PC_GUARD;
            default:  phase_code = PC_IDLE;
        endcase
    end

    assign tone_out = (phase_next == PH_ACK) ? tone_next : '0;

    assign result.tone_number  = tone_out;
    assign result.tone_low_hz  = pair_low(tone_out);
    assign result.tone_high_hz = pair_high(tone_out);
    assign result.event_code   = ev;
    assign result.phase_now    = phase_code;
    assign result.queued_count = COUNT_W'(fill_next);

    r2oc_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (res_ready),
        .in_data   (result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_result)
    );

    assign m_axis_tdata = OUT_TDATA_W'(m_result);

    // Checks on sequencer consistency
    `R2OC_ASSERT(a_tone_only_in_ack, (tone_reg != '0) |-> (phase_reg == PH_ACK), "tone on outside acknowledge wait")
    `R2OC_ASSERT(a_idle_queue_empty, (phase_reg == PH_IDLE) |-> (fill_reg == '0), "digits left queued while idle")
    `R2OC_ASSERT(a_guard_nonzero, (phase_reg == PH_GUARD) |-> (guard_reg != '0), "guard phase with no time left")
    `R2OC_ASSERT(a_fill_bound, fill_reg <= FILL_W'(QUEUE_DEPTH), "queue fill past depth")
    `R2OC_ASSERT(a_result_follows, (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid, "no result after a request transfer")

endmodule
